/* rtl/core/cts_pkg.sv */
// Package for the CAN traffic statistics block: request codes, default sizes,
// fixed-point load constants and the multiplier status type.
// No dependencies.
package cts_pkg;

  localparam int ID_ENTRIES_DEF  = 2048;
  localparam int RATE_WINDOW_DEF = 10;
  localparam int MUL_W           = 64;

  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [3:0] SIGMA_RESET = 4'd3;

  // load = floor(delta * 32 / 125) for delta below the clamp point,
  // done as (delta * 32 * LOAD_RECIP) >> LOAD_SHIFT
  localparam logic [17:0] LOAD_RECIP       = 18'd134218;
  localparam int          LOAD_SHIFT       = 24;
  localparam logic [31:0] LOAD_CLAMP_DELTA = 32'd3907;
  localparam logic [9:0]  LOAD_MAX         = 10'd1000;

  localparam logic [6:0] PCT_SCALE = 7'd100;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

/* rtl/core/can_traffic_statistics.sv */
// CAN traffic statistics top level: count and seen-mark memories, top-3 scan,
// rate history and the burst sequencer. Depends on cts_pkg and cts_mul.
//
//   channel | signals                                  | role
//   in      | in_valid/in_ready, req_type, can_id      | frame, tick or clear request
//   out     | out_valid/out_ready, statistics fields   | one transfer per tick
//   cfg     | cfg_we, cfg_wdata                        | burst threshold (sigma) write
//
// Frame: count memory read, then write back.
// Tick: a scan over all ID_ENTRIES table entries, then 11 products on the shared
//   shift-add multiplier, then the result register.
// Clear: sweeps all entries of both memories; the same sweep runs after reset.
// in_ready is low while any item is in work; a tick waits in its last state
//   while the previous result is not yet taken.
module can_traffic_statistics #(
  parameter int ID_ENTRIES  = cts_pkg::ID_ENTRIES_DEF,
  parameter int RATE_WINDOW = cts_pkg::RATE_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [10:0] can_id,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] total_frames,
  output logic [15:0] frames_per_second,
  output logic [11:0] window_unique_ids,
  output logic [11:0] total_unique_ids,
  output logic [9:0]  bus_load_tenths,
  output logic        burst,
  output logic [10:0] first_id,
  output logic [31:0] first_count,
  output logic [10:0] second_id,
  output logic [31:0] second_count,
  output logic [10:0] third_id,
  output logic [31:0] third_count
);

  localparam int IW    = $clog2(ID_ENTRIES);
  localparam int FW    = $clog2(RATE_WINDOW + 1);
  localparam int SUM_W = 16 + $clog2(RATE_WINDOW);
  localparam int SQ_W  = 32 + $clog2(RATE_WINDOW);
  localparam int MW    = cts_pkg::MUL_W;
  localparam logic [MW-1:0] W_M   = MW'(RATE_WINDOW);
  localparam logic [MW-1:0] W_SQ  = MW'(RATE_WINDOW * RATE_WINDOW);
  localparam logic [IW-1:0] LAST  = IW'(ID_ENTRIES - 1);
  localparam logic [FW-1:0] W_F   = FW'(RATE_WINDOW);

  localparam logic [3:0] STEP_LOAD  = 4'd0;
  localparam logic [3:0] STEP_OLDSQ = 4'd1;
  localparam logic [3:0] STEP_FPSQ  = 4'd2;
  localparam logic [3:0] STEP_WF    = 4'd3;
  localparam logic [3:0] STEP_WSQ   = 4'd4;
  localparam logic [3:0] STEP_SSQ   = 4'd5;
  localparam logic [3:0] STEP_VAR   = 4'd6;
  localparam logic [3:0] STEP_SIG2  = 4'd7;
  localparam logic [3:0] STEP_RHS   = 4'd8;
  localparam logic [3:0] STEP_DD    = 4'd9;
  localparam logic [3:0] STEP_LHS   = 4'd10;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_FWR      = 8'b0000_0010,
    ST_SWEEP    = 8'b0000_0100,
    ST_SCAN     = 8'b0000_1000,
    ST_SCAN_END = 8'b0001_0000,
    ST_MSTART   = 8'b0010_0000,
    ST_MWAIT    = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t state;

  // memories
  logic [31:0] cnt_mem  [ID_ENTRIES];
  logic        mark_mem [ID_ENTRIES];
  logic [31:0] cnt_rdata;
  logic        mark_rdata;
  logic [IW-1:0] raddr;
  logic          cnt_we, mark_we, mark_wdata;
  logic [IW-1:0] cnt_waddr, mark_waddr;
  logic [31:0]   cnt_wdata;

  // scalars
  logic [3:0]  sigma;
  logic [31:0] frame_total, frames_at_tick;
  logic [11:0] wuniq, tuniq;
  logic [IW-1:0] id_q;
  logic          id_ok;
  logic [IW-1:0] sweep_cnt, scan_cnt, s_idx;
  logic          s_valid;

  logic [31:0] top_cnt [3];
  logic [IW-1:0] top_id [3];

  // rate history and burst arithmetic
  logic [15:0]      hist [RATE_WINDOW];
  logic [FW-1:0]    fill;
  logic [SUM_W-1:0] rsum;
  logic [SQ_W-1:0]  rsq;
  logic [15:0]      fps_q;
  logic [16:0]      loadx;
  logic             load_clamp;
  logic [9:0]       load_q;
  logic [3:0]       step;
  logic [MW-1:0]    oldsq_q, wf_q, wsq_q, ssq_q, varc_q, sig2_q, rhs_q, dd_q;
  logic             burst_q;
  logic             full;
  logic [15:0]      old;

  logic              mul_start;
  logic [MW-1:0]     op_a, op_b, prod;
  cts_pkg::mul_stat_t mstat;

  logic in_acc;
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign full     = (fill >= W_F);
  assign old      = hist[RATE_WINDOW-1];
  assign mul_start = (state == ST_MSTART);

  cts_mul #(.WIDTH(MW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (op_a),
    .op_b    (op_b),
    .product (prod),
    .stat    (mstat)
  );

  always_comb begin
    case (step)
      STEP_LOAD:  begin op_a = MW'(loadx);  op_b = MW'(cts_pkg::LOAD_RECIP); end
      STEP_OLDSQ: begin op_a = MW'(old);    op_b = MW'(old); end
      STEP_FPSQ:  begin op_a = MW'(fps_q);  op_b = MW'(fps_q); end
      STEP_WF:    begin op_a = MW'(fps_q);  op_b = W_M; end
      STEP_WSQ:   begin op_a = MW'(rsq);    op_b = W_M; end
      STEP_SSQ:   begin op_a = MW'(rsum);   op_b = MW'(rsum); end
      STEP_VAR:   begin op_a = wsq_q - ssq_q; op_b = MW'(cts_pkg::PCT_SCALE); end
      STEP_SIG2:  begin op_a = MW'(sigma);  op_b = MW'(sigma); end
      STEP_RHS:   begin op_a = sig2_q;      op_b = varc_q; end
      STEP_DD:    begin op_a = wf_q - MW'(rsum); op_b = wf_q - MW'(rsum); end
      STEP_LHS:   begin op_a = dd_q;        op_b = MW'(cts_pkg::PCT_SCALE); end
      default:    begin op_a = '0;          op_b = '0; end
    endcase
  end

  // memory port control
  always_comb begin
    raddr      = (state == ST_SCAN) ? scan_cnt : can_id[IW-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = id_q;
    cnt_wdata  = (cnt_rdata == 32'hFFFF_FFFF) ? cnt_rdata : cnt_rdata + 32'd1;
    mark_we    = 1'b0;
    mark_waddr = id_q;
    mark_wdata = 1'b1;
    unique case (state)
      ST_FWR: begin
        cnt_we  = id_ok;
        mark_we = id_ok && !mark_rdata;
      end
      ST_SWEEP: begin
        cnt_we     = 1'b1;
        cnt_waddr  = sweep_cnt;
        cnt_wdata  = '0;
        mark_we    = 1'b1;
        mark_waddr = sweep_cnt;
        mark_wdata = 1'b0;
      end
      ST_SCAN: begin
        // drop window marks as the scan passes
        mark_we    = 1'b1;
        mark_waddr = scan_cnt;
        mark_wdata = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rdata <= mark_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma <= cts_pkg::SIGMA_RESET;
    end else if (cfg_we) begin
      sigma <= cfg_wdata;
    end
  end

  // top-3 insertion, ascending scan so ties keep the lower id
  always_ff @(posedge clk) begin
    if (in_acc && req_type == cts_pkg::REQ_TICK) begin
      for (int k = 0; k < 3; k++) begin
        top_cnt[k] <= '0;
        top_id[k]  <= '0;
      end
    end else if (s_valid && cnt_rdata != '0) begin
      if (cnt_rdata > top_cnt[0]) begin
        top_cnt[2] <= top_cnt[1]; top_id[2] <= top_id[1];
        top_cnt[1] <= top_cnt[0]; top_id[1] <= top_id[0];
        top_cnt[0] <= cnt_rdata;  top_id[0] <= s_idx;
      end else if (cnt_rdata > top_cnt[1]) begin
        top_cnt[2] <= top_cnt[1]; top_id[2] <= top_id[1];
        top_cnt[1] <= cnt_rdata;  top_id[1] <= s_idx;
      end else if (cnt_rdata > top_cnt[2]) begin
        top_cnt[2] <= cnt_rdata;  top_id[2] <= s_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_SWEEP;
      sweep_cnt      <= '0;
      scan_cnt       <= '0;
      s_valid        <= 1'b0;
      frame_total    <= '0;
      frames_at_tick <= '0;
      wuniq          <= '0;
      tuniq          <= '0;
      fill           <= '0;
      rsum           <= '0;
      rsq            <= '0;
      step           <= STEP_LOAD;
      out_valid      <= 1'b0;
    end else begin
      s_valid <= (state == ST_SCAN);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (req_type)
              cts_pkg::REQ_FRAME: begin
                if (frame_total != 32'hFFFF_FFFF) begin
                  frame_total <= frame_total + 32'd1;
                end
                id_q  <= can_id[IW-1:0];
                id_ok <= ({21'd0, can_id} < 32'(ID_ENTRIES));
                state <= ST_FWR;
              end
              cts_pkg::REQ_TICK: begin
                fps_q      <= ((frame_total - frames_at_tick) >= 32'h0000_8000) ? 16'hFFFF
                              : {frame_total[14:0] - frames_at_tick[14:0], 1'b0};
                load_clamp <= ((frame_total - frames_at_tick) >= cts_pkg::LOAD_CLAMP_DELTA);
                loadx      <= {frame_total[11:0] - frames_at_tick[11:0], 5'd0};
                scan_cnt   <= '0;
                state      <= ST_SCAN;
              end
              cts_pkg::REQ_CLEAR: begin
                frame_total    <= '0;
                frames_at_tick <= '0;
                wuniq          <= '0;
                tuniq          <= '0;
                fill           <= '0;
                rsum           <= '0;
                rsq            <= '0;
                sweep_cnt      <= '0;
                state          <= ST_SWEEP;
              end
              default: ;
            endcase
          end
        end
        ST_FWR: begin
          if (id_ok) begin
            if (cnt_rdata == '0) begin
              tuniq <= tuniq + 12'd1;
            end
            if (!mark_rdata) begin
              wuniq <= wuniq + 12'd1;
            end
          end
          state <= ST_IDLE;
        end
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          s_idx    <= scan_cnt;
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == LAST) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          step  <= STEP_LOAD;
          state <= ST_MSTART;
        end
        ST_MSTART: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mstat.done) begin
            step  <= step + 4'd1;
            state <= ST_MSTART;
            case (step)
              STEP_LOAD:  load_q  <= load_clamp ? cts_pkg::LOAD_MAX
                                     : prod[cts_pkg::LOAD_SHIFT +: 10];
              STEP_OLDSQ: oldsq_q <= prod;
              STEP_FPSQ: begin
                // advance the history: drop the oldest when full, push fps
                rsum <= rsum - (full ? SUM_W'(old) : '0) + SUM_W'(fps_q);
                rsq  <= rsq - (full ? SQ_W'(oldsq_q) : '0) + SQ_W'(prod);
                fill <= full ? W_F : fill + 1'b1;
                for (int i = RATE_WINDOW - 1; i > 0; i--) begin
                  hist[i] <= hist[i-1];
                end
                hist[0] <= fps_q;
              end
              STEP_WF:   wf_q   <= prod;
              STEP_WSQ:  wsq_q  <= prod;
              STEP_SSQ:  ssq_q  <= prod;
              STEP_VAR:  varc_q <= (prod < W_SQ) ? W_SQ : prod;
              STEP_SIG2: sig2_q <= prod;
              STEP_RHS:  rhs_q  <= prod;
              STEP_DD:   dd_q   <= prod;
              STEP_LHS: begin
                burst_q <= (fill == W_F) && (wf_q > MW'(rsum)) && (prod > rhs_q);
                state   <= ST_DONE;
              end
              default: ;
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid) begin
            total_frames      <= frame_total;
            frames_per_second <= fps_q;
            window_unique_ids <= wuniq;
            total_unique_ids  <= tuniq;
            bus_load_tenths   <= load_q;
            burst             <= burst_q;
            first_id          <= 11'(top_id[0]);
            first_count       <= top_cnt[0];
            second_id         <= 11'(top_id[1]);
            second_count      <= top_cnt[1];
            third_id          <= 11'(top_id[2]);
            third_count       <= top_cnt[2];
            out_valid         <= 1'b1;
            frames_at_tick    <= frame_total;
            wuniq             <= '0;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_tuniq_bound: assert property (@(posedge clk) disable iff (rst)
    tuniq <= 12'(ID_ENTRIES))
    else $error("total unique count beyond table size");

  a_wuniq_le_tuniq: assert property (@(posedge clk) disable iff (rst)
    wuniq <= tuniq)
    else $error("window unique count above total unique count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= W_F)
    else $error("rate history fill beyond window");

  a_idle_mul_free: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mstat.busy)
    else $error("multiplier busy while block is idle");

  a_mul_after_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |=> mstat.busy)
    else $error("multiplier did not start");

endmodule

/* rtl/core/cts_mul.sv */
// Shift-add multiplier shared by all statistics arithmetic, one operand bit per cycle.
// Depends on cts_pkg (mul_stat_t, MUL_W).
module cts_mul #(
  parameter int WIDTH = cts_pkg::MUL_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [WIDTH-1:0]    op_a,
  input  logic [WIDTH-1:0]    op_b,
  output logic [WIDTH-1:0]    product,
  output cts_pkg::mul_stat_t  stat
);

  logic [WIDTH-1:0] mcand;
  logic [WIDTH-1:0] mplier;
  logic             busy;
  logic             done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        product <= '0;
        mcand   <= op_a;
        mplier  <= op_b;
      end else if (busy) begin
        if (mplier == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (mplier[0]) begin
            product <= product + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
